/* sv/tsop_pkg.sv */
// Package for the TCP SYN option parser: word types, parse phases, option codes.
// No dependencies; every other file in the block imports it.
`timescale 1ns / 1ps

package tsop_pkg;

	// Parser phase within the options area
	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_SIZE = 2'd1,
		PH_BODY = 2'd2,
		PH_STOP = 2'd3
	} tsop_phase_t;

	// Option kinds
	localparam logic [7:0] KIND_EOL   = 8'd0;
	localparam logic [7:0] KIND_NOP   = 8'd1;
	localparam logic [7:0] KIND_MSS   = 8'd2;
	localparam logic [7:0] KIND_WSCL  = 8'd3;
	localparam logic [7:0] KIND_SACK  = 8'd4;
	localparam logic [7:0] KIND_STAMP = 8'd8;

	// Well-formed option lengths
	localparam logic [7:0] LEN_MSS   = 8'd4;
	localparam logic [7:0] LEN_WSCL  = 8'd3;
	localparam logic [7:0] LEN_SACK  = 8'd2;
	localparam logic [7:0] LEN_STAMP = 8'd10;

	// Length byte values with special handling
	localparam logic [7:0] LEN_ZERO = 8'd0;
	localparam logic [7:0] LEN_ONE  = 8'd1;

	// Bit positions in the found flags
	localparam int FL_MSS   = 0;
	localparam int FL_SCALE = 1;
	localparam int FL_SACK  = 2;
	localparam int FL_STAMP = 3;

	localparam logic [3:0] SCALE_MAX = 4'd14;

	// Configuration register indexes
	localparam logic [1:0] CFG_MSS_FLOOR   = 2'd0;
	localparam logic [1:0] CFG_MSS_CEILING = 2'd1;
	localparam logic [1:0] CFG_RECV_SCALE  = 2'd2;

	// Input word: one option byte
	typedef struct packed {
		logic [7:0]  opt_byte;
		logic        seg_first;
		logic        seg_last;
		logic [31:0] now_usec;
	} tsop_in_t;

	// Result word: one per segment
	typedef struct packed {
		logic        mss_valid;
		logic [15:0] send_mss;
		logic        scale_ok;
		logic [3:0]  send_scale;
		logic [3:0]  recv_scale;
		logic        sack_ok;
		logic        stamp_ok;
		logic [31:0] recent_stamp;
		logic [31:0] recent_stamp_time;
	} tsop_out_t;

	// Configuration registers
	typedef struct packed {
		logic [15:0] mss_floor;
		logic [15:0] mss_ceiling;
		logic [3:0]  recv_scale_default;
	} tsop_cfg_t;

	// Latched option values, as they stand after the current byte
	typedef struct packed {
		logic [3:0]  flags;
		logic [15:0] mss;
		logic [3:0]  scale;
		logic [31:0] stamp;
		logic [31:0] stamp_time;
	} tsop_held_t;

endpackage

/* sv/tsop_parser.sv */
// Option walker: phase, kind, length, body shift and latched option values.
// Depends on tsop_pkg. Exposes the latched values including the current byte.
`timescale 1ns / 1ps

module tsop_parser import tsop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  tsop_in_t   in_word,
	input  tsop_cfg_t  cfg,
	output tsop_held_t held_next
);

	tsop_phase_t phase_q, phase_n;
	logic [7:0]  kind_q, kind_n;
	logic [7:0]  size_q, size_n;
	logic [7:0]  idx_q, idx_n;
	logic [63:0] shift_q, shift_n;
	tsop_held_t  held_q;

	// Next state for one byte
	always_comb begin
		logic        fin;
		logic [15:0] mss_v;
		tsop_phase_t phase_b;
		logic [3:0]  flags_b;

		fin       = 1'b0;
		mss_v     = 16'd0;
		phase_b   = in_word.seg_first ? PH_KIND : phase_q;
		flags_b   = in_word.seg_first ? 4'd0 : held_q.flags;
		phase_n   = phase_b;
		kind_n    = kind_q;
		size_n    = size_q;
		idx_n     = idx_q;
		shift_n   = shift_q;
		held_next = held_q;
		held_next.flags = flags_b;

		unique case (phase_b)
			PH_KIND: begin
				if (in_word.opt_byte == KIND_EOL) begin
					phase_n = PH_STOP;
				end else if (in_word.opt_byte != KIND_NOP) begin
					kind_n  = in_word.opt_byte;
					phase_n = PH_SIZE;
				end
			end
			PH_SIZE: begin
				size_n  = in_word.opt_byte;
				idx_n   = 8'd0;
				shift_n = 64'd0;
				if (in_word.opt_byte == LEN_ZERO) begin
					phase_n = PH_STOP;
				end else if (in_word.opt_byte == LEN_ONE) begin
					phase_n = PH_KIND;
				end else if (in_word.opt_byte == LEN_SACK) begin
					fin = 1'b1;
				end else begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				shift_n = {shift_q[55:0], in_word.opt_byte};
				idx_n   = idx_q + 8'd1;
				fin     = ({1'b0, idx_n} + 9'd2) >= {1'b0, size_q};
			end
			PH_STOP: begin
			end
		endcase

		// Option complete: latch it if well formed
		if (fin) begin
			phase_n = PH_KIND;
			if (kind_n == KIND_MSS && size_n == LEN_MSS) begin
				mss_v = shift_n[15:0];
				if (mss_v > cfg.mss_ceiling)
					mss_v = cfg.mss_ceiling;
				if (mss_v < cfg.mss_floor)
					mss_v = cfg.mss_floor;
				held_next.mss = mss_v;
				held_next.flags[FL_MSS] = 1'b1;
			end else if (kind_n == KIND_WSCL && size_n == LEN_WSCL) begin
				held_next.scale = (shift_n[7:0] > {4'd0, SCALE_MAX}) ? SCALE_MAX
				                                                     : shift_n[3:0];
				held_next.flags[FL_SCALE] = 1'b1;
			end else if (kind_n == KIND_SACK && size_n == LEN_SACK) begin
				held_next.flags[FL_SACK] = 1'b1;
			end else if (kind_n == KIND_STAMP && size_n == LEN_STAMP) begin
				held_next.stamp      = shift_n[63:32];
				held_next.stamp_time = in_word.now_usec;
				held_next.flags[FL_STAMP] = 1'b1;
			end
		end

		// Last byte ends the segment
		if (in_word.seg_last)
			phase_n = PH_STOP;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KIND;
			kind_q  <= 8'd0;
			size_q  <= 8'd0;
			idx_q   <= 8'd0;
			shift_q <= 64'd0;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			size_q  <= size_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
			held_q  <= held_next;
		end
	end

endmodule

/* sv/tsop_result.sv */
// Result register: masks latched option values by their flags and holds the word.
// Depends on tsop_pkg.
`timescale 1ns / 1ps

module tsop_result import tsop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  tsop_held_t held,
	input  logic [3:0] recv_scale_default,
	input  logic       res_stall,
	output logic       res_valid,
	output tsop_out_t  res_word
);

	tsop_out_t word_n;
	logic      valid_q;
	tsop_out_t word_q;

	// Clear every field whose option was not seen
	always_comb begin
		word_n.mss_valid         = held.flags[FL_MSS];
		word_n.send_mss          = held.flags[FL_MSS] ? held.mss : 16'd0;
		word_n.scale_ok          = held.flags[FL_SCALE];
		word_n.send_scale        = held.flags[FL_SCALE] ? held.scale : 4'd0;
		word_n.recv_scale        = held.flags[FL_SCALE] ? recv_scale_default : 4'd0;
		word_n.sack_ok           = held.flags[FL_SACK];
		word_n.stamp_ok          = held.flags[FL_STAMP];
		word_n.recent_stamp      = held.flags[FL_STAMP] ? held.stamp : 32'd0;
		word_n.recent_stamp_time = held.flags[FL_STAMP] ? held.stamp_time : 32'd0;
	end

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_n;
		end
	end

	assign res_valid = valid_q;
	assign res_word  = word_q;

endmodule

/* sv/tcp_syn_option_parser.sv */
// Top level of the TCP SYN option parser: config registers, handshake, assertions.
// Depends on tsop_pkg, tsop_parser and tsop_result.
`timescale 1ns / 1ps
//
// Usage:
//   opt channel: one option byte per word, with seg_first on the first byte of a
//   segment and seg_last on its last. A word is taken when opt_valid is high and
//   opt_stall is low. Segments without options send no words.
//   res channel: one result word per seg_last byte, shown on res_word in the cycle
//   after that byte is taken, held while res_stall is high.
//   cfg channel: register writes (index, data); cfg_ready is always high. Write
//   only while no segment is in flight.
// Throughput: one byte per cycle while opt_stall is low; the whole per-byte decode
// sits between the parser state registers, and the result word is registered.
// Stall: bytes that carry no seg_last keep flowing while a result waits; a
// seg_last byte is stalled only while the result register is full and stalled.
// Reset: parser waits for a kind byte, found flags clear, no result pending,
// registers return to floor 88, ceiling 1460, receive scale 7.
//

module tcp_syn_option_parser import tsop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        opt_valid,
	output logic        opt_stall,
	input  tsop_in_t    opt_word,
	output logic        res_valid,
	input  logic        res_stall,
	output tsop_out_t   res_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tsop_cfg_t  cfg_q;
	tsop_held_t held_next;
	logic       opt_accept;
	logic       res_load;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mss_floor          <= 16'd88;
			cfg_q.mss_ceiling        <= 16'd1460;
			cfg_q.recv_scale_default <= 4'd7;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MSS_FLOOR:   cfg_q.mss_floor          <= cfg_data;
				CFG_MSS_CEILING: cfg_q.mss_ceiling        <= cfg_data;
				CFG_RECV_SCALE:  cfg_q.recv_scale_default <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Only a byte that makes a result needs room in the result register
	assign opt_stall  = res_valid & res_stall & opt_word.seg_last;
	assign opt_accept = opt_valid & ~opt_stall;
	assign res_load   = opt_accept & opt_word.seg_last;

	tsop_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (opt_accept),
		.in_word   (opt_word),
		.cfg       (cfg_q),
		.held_next (held_next)
	);

	tsop_result u_result (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (res_load),
		.held               (held_next),
		.recv_scale_default (cfg_q.recv_scale_default),
		.res_stall          (res_stall),
		.res_valid          (res_valid),
		.res_word           (res_word)
	);

	// A new result only follows a taken last byte
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(opt_valid && !opt_stall && opt_word.seg_last))
		else $error("result without a taken last byte");

	// A pending stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall && opt_word.seg_last) |-> opt_stall)
		else $error("last byte taken while result stalled");

	// Scale fields follow their flag
	a_scale_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_word.scale_ok) |->
			(res_word.send_scale == 4'd0 && res_word.recv_scale == 4'd0))
		else $error("scale fields set without scale option");

	// Peer shift stays clamped
	a_scale_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.send_scale <= SCALE_MAX))
		else $error("send_scale above limit");

endmodule
